// ===== design/ptp_pkg.sv =====
// ----------------------------------------------------------------------------
// ptp_pkg
// Shared types and constants for the procedural texture pattern block.
// ----------------------------------------------------------------------------
package ptp_pkg;

   localparam int COORD_BITS     = 32;
   localparam int SIZE_BITS      = 32;
   localparam int COLOR_BITS     = 24;
   localparam int CSR_INDEX_BITS = 2;
   localparam int CSR_DATA_BITS  = 32;

   localparam logic [SIZE_BITS-1:0]  CELL_SIZE_RESET = 32'h0001_0000;
   localparam logic [COLOR_BITS-1:0] COLOR_A_RESET   = 24'h00_0000;
   localparam logic [COLOR_BITS-1:0] COLOR_B_RESET   = 24'hFF_FFFF;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_MODE    = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SIZE    = 2'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_COLOR_A = 2'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_COLOR_B = 2'd3;

   typedef enum logic [1:0] {
      MODE_PLAIN   = 2'd0,
      MODE_STRIPES = 2'd1,
      MODE_CHECKER = 2'd2,
      MODE_RINGS   = 2'd3
   } mode_type;

   typedef struct packed {
      logic signed [COORD_BITS-1:0] hit_x;
      logic signed [COORD_BITS-1:0] hit_z;
   } req_type;

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
   } rsp_type;

endpackage

// ===== design/procedural_texture_pattern.sv =====
// ----------------------------------------------------------------------------
// procedural_texture_pattern
// Plain / stripe / checker / ring texture: one hit point in, one color out.
//
//   channel  dir  ports                         beat
//   req      in   req_valid req_stall req_data  hit_x, hit_z (Q16.16)
//   rsp      out  rsp_valid rsp_stall rsp_data  red, green, blue
//   csr      in   csr_we csr_index csr_wdata    mode, cell size, colors
//
// One beat per cycle while rsp is not stalled. The pipeline depth is set by the
// one-bit-per-stage square root and divider pipelines.
// Synchronous reset clears valid bits and loads register defaults.
// A stall on a valid rsp beat freezes the whole pipe and raises req_stall that cycle.
// ----------------------------------------------------------------------------
module procedural_texture_pattern (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  ptp_pkg::req_type                   req_data,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output ptp_pkg::rsp_type                   rsp_data,
   input  logic                               csr_we,
   input  logic [ptp_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [ptp_pkg::CSR_DATA_BITS-1:0]  csr_wdata
);
   import ptp_pkg::*;

   localparam int CB  = COORD_BITS;
   localparam int LO  = (CB + 1) / 2;
   localparam int HI  = CB - LO;
   localparam int LAT = 5 + 2 * CB;
   localparam int DLY = 3 + CB;

   // configuration
   mode_type              mode_ff,  mode_in;
   logic [SIZE_BITS-1:0]  size_ff,  size_in;
   logic [COLOR_BITS-1:0] col_a_ff, col_a_in;
   logic [COLOR_BITS-1:0] col_b_ff, col_b_in;
   logic [SIZE_BITS-1:0]  eff_size;

   always_comb begin
      mode_in  = mode_ff;
      size_in  = size_ff;
      col_a_in = col_a_ff;
      col_b_in = col_b_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_MODE:    mode_in  = mode_type'(csr_wdata[1:0]);
            CSR_SIZE:    size_in  = csr_wdata[SIZE_BITS-1:0];
            CSR_COLOR_A: col_a_in = csr_wdata[COLOR_BITS-1:0];
            CSR_COLOR_B: col_b_in = csr_wdata[COLOR_BITS-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= MODE_PLAIN;
         size_ff  <= CELL_SIZE_RESET;
         col_a_ff <= COLOR_A_RESET;
         col_b_ff <= COLOR_B_RESET;
      end else begin
         mode_ff  <= mode_in;
         size_ff  <= size_in;
         col_a_ff <= col_a_in;
         col_b_ff <= col_b_in;
      end
   end

   assign eff_size = (size_ff == '0) ? SIZE_BITS'(1) : size_ff;

   // pipe control
   logic           en;
   logic [LAT-1:0] vld_ff, vld_in;

   assign en        = !(rsp_valid && rsp_stall);
   assign req_stall = reset || !en;
   assign vld_in    = {vld_ff[LAT-2:0], req_valid};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= vld_in;
      end
   end

   assign rsp_valid = vld_ff[LAT-1];

   // stage 0: magnitudes and sign flags
   logic [CB-1:0] mx_ff, mx_in, mz_ff, mz_in;
   logic          sx_in, sz_in;
   logic [3:0]    flg_ff [DLY];
   logic          px, pz;

   assign mx_in = req_data.hit_x[CB-1] ? CB'(-req_data.hit_x) : req_data.hit_x;
   assign mz_in = req_data.hit_z[CB-1] ? CB'(-req_data.hit_z) : req_data.hit_z;
   assign sx_in = !req_data.hit_x[CB-1] && (req_data.hit_x != '0);
   assign sz_in = !req_data.hit_z[CB-1] && (req_data.hit_z != '0);

   logic sx_ff, sz_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         mx_ff <= mx_in;
         mz_ff <= mz_in;
         sx_ff <= sx_in;
         sz_ff <= sz_in;
      end
   end

   // axis parities
   ptp_div #(.WIDTH(CB)) u_div_x (
      .clock(clock), .en(en), .dividend(mx_ff), .divisor(eff_size), .parity(px)
   );
   ptp_div #(.WIDTH(CB)) u_div_z (
      .clock(clock), .en(en), .dividend(mz_ff), .divisor(eff_size), .parity(pz)
   );

   // sign flags meet axis parities, then wait for the ring result
   logic [1:0]    sgn_out;
   logic [1:0]    sgn_dly [CB];

   always_ff @(posedge clock) begin
      if (en) begin
         sgn_dly[0] <= {sx_ff, sz_ff};
         for (int i = 1; i < CB; i++) begin
            sgn_dly[i] <= sgn_dly[i-1];
         end
      end
   end

   assign sgn_out = sgn_dly[CB-1];

   always_ff @(posedge clock) begin
      if (en) begin
         flg_ff[0] <= {sgn_out, px, pz};
         for (int i = 1; i < DLY; i++) begin
            flg_ff[i] <= flg_ff[i-1];
         end
      end
   end

   // squares: split partial products, recombine, sum
   logic [2*HI-1:0]    xhh_ff, zhh_ff;
   logic [HI+LO-1:0]   xhl_ff, zhl_ff;
   logic [2*LO-1:0]    xll_ff, zll_ff;
   logic [2*CB-1:0]    sqx_ff, sqz_ff, sqx_in, sqz_in, sum_ff;
   logic [CB-1:0]      root;
   logic               pr;

   always_ff @(posedge clock) begin
      if (en) begin
         xhh_ff <= (2*HI)'(mx_ff[CB-1:LO]) * (2*HI)'(mx_ff[CB-1:LO]);
         xhl_ff <= (HI+LO)'(mx_ff[CB-1:LO]) * (HI+LO)'(mx_ff[LO-1:0]);
         xll_ff <= (2*LO)'(mx_ff[LO-1:0]) * (2*LO)'(mx_ff[LO-1:0]);
         zhh_ff <= (2*HI)'(mz_ff[CB-1:LO]) * (2*HI)'(mz_ff[CB-1:LO]);
         zhl_ff <= (HI+LO)'(mz_ff[CB-1:LO]) * (HI+LO)'(mz_ff[LO-1:0]);
         zll_ff <= (2*LO)'(mz_ff[LO-1:0]) * (2*LO)'(mz_ff[LO-1:0]);
      end
   end

   assign sqx_in = ((2*CB)'(xhh_ff) << (2*LO)) + ((2*CB)'(xhl_ff) << (LO+1))
                 + (2*CB)'(xll_ff);
   assign sqz_in = ((2*CB)'(zhh_ff) << (2*LO)) + ((2*CB)'(zhl_ff) << (LO+1))
                 + (2*CB)'(zll_ff);

   always_ff @(posedge clock) begin
      if (en) begin
         sqx_ff <= sqx_in;
         sqz_ff <= sqz_in;
         sum_ff <= sqx_ff + sqz_ff;
      end
   end

   ptp_isqrt #(.WIDTH(CB)) u_isqrt (
      .clock(clock), .en(en), .radicand(sum_ff), .root(root)
   );

   ptp_div #(.WIDTH(CB)) u_div_r (
      .clock(clock), .en(en), .dividend(root), .divisor(eff_size), .parity(pr)
   );

   // color select
   logic [3:0]            flg;
   logic                  idx;
   logic [COLOR_BITS-1:0] col;
   rsp_type               out_ff, out_in;

   assign flg = flg_ff[DLY-1];

   always_comb begin
      case (mode_ff)
         MODE_PLAIN:   idx = 1'b0;
         MODE_STRIPES: idx = flg[3] ? flg[1] : !flg[1];
         MODE_CHECKER: idx = !(flg[3] ^ flg[2] ^ flg[1] ^ flg[0]);
         MODE_RINGS:   idx = pr;
         default:      idx = 1'b0;
      endcase
      col          = idx ? col_b_ff : col_a_ff;
      out_in.red   = col[23:16];
      out_in.green = col[15:8];
      out_in.blue  = col[7:0];
   end

   always_ff @(posedge clock) begin
      if (en) begin
         out_ff <= out_in;
      end
   end

   assign rsp_data = out_ff;

endmodule

// ===== design/ptp_div.sv =====
// ----------------------------------------------------------------------------
// ptp_div
// Pipelined restoring divider, one quotient bit per stage; only the parity
// of the quotient comes out.
// ----------------------------------------------------------------------------
module ptp_div #(
   parameter int WIDTH = ptp_pkg::COORD_BITS
) (
   input  logic                          clock,
   input  logic                          en,
   input  logic [WIDTH-1:0]              dividend,
   input  logic [ptp_pkg::SIZE_BITS-1:0] divisor,
   output logic                          parity
);
   import ptp_pkg::*;

   logic [SIZE_BITS-1:0] rem_ff [WIDTH-1];
   logic [WIDTH-1:0]     dvd_ff [WIDTH-1];
   logic                 parity_ff;

   genvar k;
   generate
      for (k = 0; k < WIDTH; k++) begin : g_stage
         logic [SIZE_BITS-1:0] rem_prev;
         logic [WIDTH-1:0]     dvd_prev;
         logic [SIZE_BITS:0]   trial;
         logic                 ge;
         logic [SIZE_BITS-1:0] rem_in;

         if (k == 0) begin : g_first
            assign rem_prev = '0;
            assign dvd_prev = dividend;
         end else begin : g_next
            assign rem_prev = rem_ff[k-1];
            assign dvd_prev = dvd_ff[k-1];
         end

         assign trial  = {rem_prev, dvd_prev[WIDTH-1]};
         assign ge     = trial >= {1'b0, divisor};
         assign rem_in = ge ? SIZE_BITS'(trial - {1'b0, divisor}) : trial[SIZE_BITS-1:0];

         if (k < WIDTH-1) begin : g_keep
            always_ff @(posedge clock) begin
               if (en) begin
                  rem_ff[k] <= rem_in;
                  dvd_ff[k] <= dvd_prev << 1;
               end
            end
         end else begin : g_last
            always_ff @(posedge clock) begin
               if (en) begin
                  parity_ff <= ge;
               end
            end
         end
      end
   endgenerate

   assign parity = parity_ff;

endmodule

// ===== design/ptp_isqrt.sv =====
// ----------------------------------------------------------------------------
// ptp_isqrt
// Pipelined digit-by-digit integer square root, one root bit per stage.
// ----------------------------------------------------------------------------
module ptp_isqrt #(
   parameter int WIDTH = ptp_pkg::COORD_BITS
) (
   input  logic               clock,
   input  logic               en,
   input  logic [2*WIDTH-1:0] radicand,
   output logic [WIDTH-1:0]   root
);
   import ptp_pkg::*;

   logic [WIDTH+1:0]   rem_ff  [WIDTH-1];
   logic [2*WIDTH-1:0] rad_ff  [WIDTH-1];
   logic [WIDTH-1:0]   root_ff [WIDTH];

   genvar k;
   generate
      for (k = 0; k < WIDTH; k++) begin : g_stage
         logic [WIDTH+1:0]   rem_prev;
         logic [2*WIDTH-1:0] rad_prev;
         logic [WIDTH-1:0]   root_prev;
         logic [WIDTH+3:0]   cur;
         logic [WIDTH+3:0]   trial;
         logic               ge;
         logic [WIDTH+1:0]   rem_in;
         logic [WIDTH-1:0]   root_in;

         if (k == 0) begin : g_first
            assign rem_prev  = '0;
            assign rad_prev  = radicand;
            assign root_prev = '0;
         end else begin : g_next
            assign rem_prev  = rem_ff[k-1];
            assign rad_prev  = rad_ff[k-1];
            assign root_prev = root_ff[k-1];
         end

         assign cur     = {rem_prev, rad_prev[2*WIDTH-1 -: 2]};
         assign trial   = {2'b00, root_prev, 2'b01};
         assign ge      = cur >= trial;
         assign rem_in  = ge ? (WIDTH+2)'(cur - trial) : cur[WIDTH+1:0];
         assign root_in = {root_prev[WIDTH-2:0], ge};

         if (k < WIDTH-1) begin : g_keep
            always_ff @(posedge clock) begin
               if (en) begin
                  rem_ff[k]  <= rem_in;
                  rad_ff[k]  <= rad_prev << 2;
                  root_ff[k] <= root_in;
               end
            end
         end else begin : g_last
            always_ff @(posedge clock) begin
               if (en) begin
                  root_ff[k] <= root_in;
               end
            end
         end
      end
   endgenerate

   assign root = root_ff[WIDTH-1];

endmodule

// ===== tb/tb_procedural_texture_pattern.sv =====
// ----------------------------------------------------------------------------
// tb_procedural_texture_pattern
// Drives hit points through the texture block under several register
// settings and checks every returned color against a local pattern model or a typed-in color.
// ----------------------------------------------------------------------------
module tb_procedural_texture_pattern;
   import ptp_pkg::*;

   localparam int LATENCY = 5 + 2*COORD_BITS;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   req_type req_data = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   rsp_type rsp_data;
   logic csr_we = 1'b0;
   logic [CSR_INDEX_BITS-1:0] csr_index = CSR_MODE;
   logic [CSR_DATA_BITS-1:0] csr_wdata = '0;

   procedural_texture_pattern u_top (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   mode_type mdl_mode;
   logic [SIZE_BITS-1:0] mdl_size;
   logic [COLOR_BITS-1:0] mdl_color_a, mdl_color_b;

   rsp_type color_queue[$];
   int errors = 0;
   bit calm = 1'b0;

   function automatic logic [COORD_BITS-1:0] magnitude(logic [COORD_BITS-1:0] v);
      return v[COORD_BITS-1] ? (~v + 1'b1) : v;
   endfunction

   function automatic logic cell_parity(logic [2*COORD_BITS-1:0] m);
      logic [2*COORD_BITS-1:0] s;
      logic [2*COORD_BITS-1:0] q;
      s = (mdl_size == 0) ? (2*COORD_BITS)'(1) : (2*COORD_BITS)'(mdl_size);
      q = m / s;
      return q[0];
   endfunction

   function automatic logic [COORD_BITS-1:0] radius(logic [COORD_BITS-1:0] mx,
                                                    logic [COORD_BITS-1:0] mz);
      logic [2*COORD_BITS:0] n;
      logic [2*COORD_BITS:0] c;
      logic [COORD_BITS-1:0] r;
      n = {1'b0, 64'(mx) * 64'(mx)} + {1'b0, 64'(mz) * 64'(mz)};
      r = '0;
      for (int b = COORD_BITS-1; b >= 0; b--) begin
         c = 65'(r | (1 << b)) * 65'(r | (1 << b));
         if (c <= n) r = r | (1 << b);
      end
      return r;
   endfunction

   function automatic rsp_type texture_color(req_type p);
      logic [COORD_BITS-1:0] mx, mz;
      logic sx, sz, px, pz, idx;
      logic [COLOR_BITS-1:0] c;
      mx = magnitude(p.hit_x);
      mz = magnitude(p.hit_z);
      sx = !p.hit_x[COORD_BITS-1] && p.hit_x != 0;
      sz = !p.hit_z[COORD_BITS-1] && p.hit_z != 0;
      px = cell_parity(mx);
      pz = cell_parity(mz);
      case (mdl_mode)
         MODE_STRIPES: idx = sx ? px : !px;
         MODE_CHECKER: idx = (sx == sz) ? (px == pz) : (px != pz);
         MODE_RINGS:   idx = cell_parity(radius(mx, mz));
         default:      idx = 1'b0;
      endcase
      c = idx ? mdl_color_b : mdl_color_a;
      return rsp_type'(c);
   endfunction

   task automatic csr_write(logic [CSR_INDEX_BITS-1:0] idx, logic [CSR_DATA_BITS-1:0] val);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      case (idx)
         CSR_MODE:    mdl_mode = mode_type'(val[1:0]);
         CSR_SIZE:    mdl_size = val;
         CSR_COLOR_A: mdl_color_a = val[COLOR_BITS-1:0];
         default:     mdl_color_b = val[COLOR_BITS-1:0];
      endcase
      @(posedge clock);
   endtask

   task automatic drain;
      req_valid <= 1'b0;
      while (color_queue.size() != 0) @(posedge clock);
      repeat (LATENCY + 4) @(posedge clock);
   endtask

   // exp_known: expected color typed in; else predicted
   task automatic send_point(req_type p, bit exp_known, rsp_type exp_c);
      if (!calm && $urandom_range(0, 7) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 5)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= p;
      color_queue.push_back(exp_known ? exp_c : texture_color(p));
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (color_queue.size() == 0) begin
            $display("%0t: unexpected beat, actual %h", $time, rsp_data);
            errors++;
         end else begin
            rsp_type e;
            e = color_queue.pop_front();
            if (e.red !== rsp_data.red || e.green !== rsp_data.green ||
                e.blue !== rsp_data.blue) begin
               $display("%0t: color mismatch, expected %h actual %h", $time, e, rsp_data);
               errors++;
            end
         end
      end
   end

   int rsp_gap = 0;
   always @(posedge clock) begin
      if (calm) rsp_stall <= 1'b0;
      else if (rsp_gap > 0) begin
         rsp_gap <= rsp_gap - 1;
         rsp_stall <= 1'b1;
      end else if ($urandom_range(0, 9) == 0) begin
         rsp_gap <= $urandom_range(0, 4);
         rsp_stall <= 1'b1;
      end else rsp_stall <= 1'b0;
   end

   typedef struct {
      logic [31:0] x;
      logic [31:0] z;
      bit known;
      logic [23:0] c;
   } point_row;

   localparam logic [31:0] MAXP = 32'h7FFF_FFFF;
   localparam logic [31:0] MINN = 32'h8000_0000;
   point_row dir_rows[] = '{
      '{32'd0, 32'd0, 1, 24'h000000},
      '{MAXP, MINN, 1, 24'h000000},
      '{MINN, MAXP, 1, 24'h000000},
      '{32'hFFFF_FFFF, 32'd1, 0, 0},
      '{32'h0001_8000, 32'h0000_8000, 0, 0},
      '{32'hFFFE_8000, 32'h0002_0000, 0, 0},
      '{MAXP, MAXP, 0, 0},
      '{MINN, MINN, 0, 0},
      '{32'h0003_0000, 32'h0004_0000, 0, 0},
      '{32'h0000_FFFF, 32'hFFFF_0001, 0, 0}
   };

   function automatic logic [31:0] rand_coord;
      case ($urandom_range(0, 3))
         0: return $urandom;
         1: return $urandom_range(0, 32'h0008_0000) - 32'h0004_0000;
         2: return $urandom_range(0, 1) ? MINN : MAXP;
         default: return $urandom_range(0, 255) - 128;
      endcase
   endfunction

   function automatic logic [31:0] rand_size;
      case ($urandom_range(0, 4))
         0: return 32'd0;
         1: return 32'hFFFF_FFFF;
         2: return $urandom_range(1, 64);
         3: return $urandom_range(32'h4000, 32'h4_0000);
         default: return $urandom;
      endcase
   endfunction

   initial begin
      mdl_mode = MODE_PLAIN;
      mdl_size = CELL_SIZE_RESET;
      mdl_color_a = COLOR_A_RESET;
      mdl_color_b = COLOR_B_RESET;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset defaults, plain mode
      foreach (dir_rows[i])
         send_point('{dir_rows[i].x, dir_rows[i].z}, dir_rows[i].known, dir_rows[i].c);
      drain();
      csr_write(CSR_COLOR_A, 32'hFF12_3456);
      csr_write(CSR_COLOR_B, 32'h00AB_CDEF);
      csr_write(CSR_SIZE, 32'd0);
      for (int m = 1; m < 4; m++) begin
         csr_write(CSR_MODE, m);
         foreach (dir_rows[i]) send_point('{dir_rows[i].x, dir_rows[i].z}, 0, 0);
         drain();
      end
      csr_write(CSR_SIZE, 32'hFFFF_FFFF);
      send_point('{MINN, MINN}, 0, 0);
      send_point('{MAXP, 32'd5}, 0, 0);
      drain();

      for (int ph = 0; ph < 10; ph++) begin
         csr_write(CSR_MODE, $urandom_range(0, 3));
         csr_write(CSR_SIZE, rand_size());
         csr_write(CSR_COLOR_A, $urandom);
         csr_write(CSR_COLOR_B, $urandom);
         if (ph == 9) calm = 1'b1;
         for (int i = 0; i < 110; i++) begin
            send_point('{rand_coord(), rand_coord()}, 0, 0);
            if (i == 55 && ph == 3) begin
               req_valid <= 1'b0;
               @(posedge clock);
               while (color_queue.size() != 0) @(posedge clock);
            end
         end
         drain();
      end

      if (errors == 0) $display("Test completed successfully");
      else $display("Test completed with failures");
      $finish;
   end

   initial begin
      #3000000;
      $display("Test completed with failures");
      $finish;
   end
endmodule
